// ===== design/escd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and lookup functions for the backslash escape decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package escd_pkg;

  // Character codes
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharStop      = 8'h63;  // 'c'
  localparam logic [7:0] CharOctOpen   = 8'h30;  // '0'
  localparam logic [7:0] CharHexOpen   = 8'h78;  // 'x'

  // Digits that end a number at once
  localparam logic [1:0] OctDigitLimit = 2'd3;
  localparam logic [1:0] HexDigitLimit = 2'd2;

  // Run queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Results one input item can cause
  localparam int MaxResults = 3;
  localparam int ResCntW    = $clog2(MaxResults + 1);
  localparam int ResIdxW    = $clog2(MaxResults);

  typedef enum logic [3:0] {
    ModeText = 4'b0001,
    ModeEsc  = 4'b0010,
    ModeOct  = 4'b0100,
    ModeHex  = 4'b1000
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_arg;
    logic       end_of_command;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_stop;
    logic       last_of_run;
  } out_item_t;

  // All results caused by one input item; count is 1 to MaxResults
  typedef struct packed {
    logic [ResCntW-1:0]          count;
    logic [MaxResults-1:0][7:0]  bytes;
    logic                        stop;
  } run_t;

  // Parser status seen by the top level
  typedef struct packed {
    parse_mode_e mode;
    logic [1:0]  digit_count;
    logic        stopped;
  } front_status_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_lookup_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  function automatic esc_lookup_t esc_lookup(input logic [7:0] b);
    esc_lookup_t r;
    r.hit   = 1'b1;
    r.value = 8'h00;
    case (b)
      8'h61:         r.value = 8'h07;  // a
      8'h62:         r.value = 8'h08;  // b
      8'h65:         r.value = 8'h1B;  // e
      8'h66:         r.value = 8'h0C;  // f
      8'h6E:         r.value = 8'h0A;  // n
      8'h72:         r.value = 8'h0D;  // r
      8'h74:         r.value = 8'h09;  // t
      8'h76:         r.value = 8'h0B;  // v
      CharBackslash: r.value = CharBackslash;
      default:       r.hit   = 1'b0;
    endcase
    return r;
  endfunction

  function automatic digit_t hex_digit(input logic [7:0] b);
    digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r.value = b[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic digit_t oct_digit(input logic [7:0] b);
    digit_t r;
    r.ok    = (b >= 8'h30 && b <= 8'h37);
    r.value = {1'b0, b[2:0]};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/escd_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the escape parser state and turns each input item into one run
// of up to three results. Depends on escd_pkg.
`default_nettype none

module escd_front
  import escd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire in_item_t      item_i,
  output run_t               run_o,
  output logic               run_valid_o,
  output front_status_t      status_o
);

  parse_mode_e mode_q, mode_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [8:0]  acc_q, acc_d;
  logic        stopped_q, stopped_d;

  logic [MaxResults-1:0][7:0] res_v;
  logic [ResCntW-1:0]         n_v;
  logic                       stop_v;

  always_comb begin
    esc_lookup_t esc;
    digit_t      dig;
    logic        oct;
    logic [7:0]  b;
    b       = item_i.in_byte;
    mode_d  = mode_q;
    dcnt_d  = dcnt_q;
    acc_d   = acc_q;
    stopped_d = stopped_q;
    res_v   = '0;
    n_v     = '0;
    stop_v  = 1'b0;
    esc     = esc_lookup(b);
    oct     = (mode_q == ModeOct);
    dig     = oct ? oct_digit(b) : hex_digit(b);

    if (stopped_q) begin
      // Drop everything until the end of the command
      if (item_i.end_of_command) begin
        mode_d    = ModeText;
        dcnt_d    = '0;
        acc_d     = '0;
        stopped_d = 1'b0;
      end
    end else begin
      case (mode_q)
        ModeEsc: begin
          mode_d = ModeText;
          if (esc.hit) begin
            res_v[n_v[ResIdxW-1:0]] = esc.value;
            n_v = n_v + 1'b1;
          end else if (b == CharStop) begin
            res_v[n_v[ResIdxW-1:0]] = 8'h00;
            n_v       = n_v + 1'b1;
            stop_v    = 1'b1;
            stopped_d = 1'b1;
          end else if (b == CharOctOpen) begin
            dcnt_d = '0;
            acc_d  = '0;
            mode_d = ModeOct;
          end else if (b == CharHexOpen) begin
            dcnt_d = '0;
            acc_d  = '0;
            mode_d = ModeHex;
          end else begin
            // Unknown escape: backslash, then the byte itself
            res_v[n_v[ResIdxW-1:0]] = CharBackslash;
            n_v = n_v + 1'b1;
            res_v[n_v[ResIdxW-1:0]] = b;
            n_v = n_v + 1'b1;
          end
        end
        ModeOct, ModeHex: begin
          if (dig.ok) begin
            acc_d  = oct ? {acc_q[5:0], dig.value[2:0]} : {acc_q[4:0], dig.value};
            dcnt_d = dcnt_q + 2'd1;
            if (dcnt_d == (oct ? OctDigitLimit : HexDigitLimit)) begin
              res_v[n_v[ResIdxW-1:0]] = acc_d[7:0];
              n_v    = n_v + 1'b1;
              mode_d = ModeText;
              dcnt_d = '0;
              acc_d  = '0;
            end
          end else begin
            // Number ended by a non-digit: flush, then treat the byte as text
            if (dcnt_q == 2'd0) begin
              res_v[n_v[ResIdxW-1:0]] = CharBackslash;
              n_v = n_v + 1'b1;
              res_v[n_v[ResIdxW-1:0]] = oct ? CharOctOpen : CharHexOpen;
              n_v = n_v + 1'b1;
            end else begin
              res_v[n_v[ResIdxW-1:0]] = acc_q[7:0];
              n_v = n_v + 1'b1;
            end
            dcnt_d = '0;
            acc_d  = '0;
            if (b == CharBackslash) begin
              mode_d = ModeEsc;
            end else begin
              mode_d = ModeText;
              res_v[n_v[ResIdxW-1:0]] = b;
              n_v = n_v + 1'b1;
            end
          end
        end
        default: begin
          if (b == CharBackslash) begin
            mode_d = ModeEsc;
          end else begin
            mode_d = ModeText;
            res_v[n_v[ResIdxW-1:0]] = b;
            n_v = n_v + 1'b1;
          end
        end
      endcase

      if (stopped_d) begin
        mode_d = ModeText;
        dcnt_d = '0;
        acc_d  = '0;
      end else if (item_i.end_of_arg || item_i.end_of_command) begin
        // Flush whatever is pending at the end of the argument
        if (mode_d == ModeEsc) begin
          res_v[n_v[ResIdxW-1:0]] = CharBackslash;
          n_v = n_v + 1'b1;
        end else if (mode_d == ModeOct || mode_d == ModeHex) begin
          if (dcnt_d == 2'd0) begin
            res_v[n_v[ResIdxW-1:0]] = CharBackslash;
            n_v = n_v + 1'b1;
            res_v[n_v[ResIdxW-1:0]] = (mode_d == ModeOct) ? CharOctOpen : CharHexOpen;
            n_v = n_v + 1'b1;
          end else begin
            res_v[n_v[ResIdxW-1:0]] = acc_d[7:0];
            n_v = n_v + 1'b1;
          end
        end
        mode_d = ModeText;
        dcnt_d = '0;
        acc_d  = '0;
      end
      if (item_i.end_of_command) begin
        stopped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeText;
      dcnt_q    <= '0;
      acc_q     <= '0;
      stopped_q <= 1'b0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      dcnt_q    <= dcnt_d;
      acc_q     <= acc_d;
      stopped_q <= stopped_d;
    end
  end

  assign run_o.count = n_v;
  assign run_o.bytes = res_v;
  assign run_o.stop  = stop_v;
  assign run_valid_o = (n_v != '0);

  assign status_o.mode        = mode_q;
  assign status_o.digit_count = dcnt_q;
  assign status_o.stopped     = stopped_q;

endmodule

`default_nettype wire

// ===== design/escd_queue.sv =====
`timescale 1ns / 1ps
// Short run queue that decouples the parser from the output sequencer.
// Depends on escd_pkg for run_t and the queue depth.
`default_nettype none

module escd_queue
  import escd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire run_t  entry_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       valid_o,
  output run_t       head_o
);

  run_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== design/escd_back.sv =====
`timescale 1ns / 1ps
// Back end: steps through the results of the run at the queue head, one per cycle
// unless the output is stalled, into the output register. Depends on escd_pkg.
`default_nettype none

module escd_back
  import escd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  wire run_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output out_item_t  out_item_o
);

  logic [ResIdxW-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic               load;
  logic               last;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last = (ResCntW'(idx_q) == head_i.count - 1'b1);
  assign pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_d.out_byte    = head_i.bytes[idx_q];
      out_d.is_stop     = head_i.stop;
      out_d.last_of_run = last;
      out_valid_d       = 1'b1;
      idx_d             = last ? '0 : idx_q + 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== design/backslash_escape_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the backslash escape decoder: parser front end, run queue, output back end.
// Depends on escd_pkg, escd_front, escd_queue and escd_back.
`default_nettype none

// Streams one raw argument byte per item and returns the decoded bytes. Simple escapes
// (a b e f n r t v and a doubled backslash), octal numbers after a backslash-zero (one
// to three digits, low 8 bits kept) and hex numbers after backslash-x (one or two
// digits) are decoded; anything malformed or unfinished comes out literally. The
// backslash-c escape yields one result with is_stop set, and every later byte is
// dropped until an item with end_of_command. An item causes zero to three results;
// last_of_run marks the final one, and an item causing none produces nothing at the
// output. The parser takes one item per cycle while the queue is not full and posts
// its results as one run into a four-entry queue; the output sequencer drains a run
// at one result per cycle while out_stall_i is low. Input stall rises only when the
// queue is full. Each result passes through the queue and then the output register.

module backslash_escape_decoder
  import escd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic          accept;
  run_t          run;
  logic          run_valid;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;
  run_t          q_head;
  front_status_t status;

  // Hold the input off only while the queue cannot take another run
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;
  // Drop items that cause no result: nothing reaches the queue
  assign push       = accept && run_valid;

  escd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .run_o       (run),
    .run_valid_o (run_valid),
    .status_o    (status)
  );

  escd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (run),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  escd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

  // A stop result stands alone: zero byte, and it closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_stop |-> out_item_o.last_of_run && out_item_o.out_byte == 8'h00)
    else $error("stop result not alone in its run");

  // The end of a command returns the parser to plain text, not stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.end_of_command |=>
      status.mode == ModeText && !status.stopped && status.digit_count == 2'd0)
    else $error("parser state not cleared at end of command");

  // While stopped, no run is queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.stopped |-> !push)
    else $error("result queued while output is stopped");

  // A run is never taken from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("run popped from empty queue");

endmodule

`default_nettype wire
